>>> rtl/sctfc_pkg.sv
// Package: shared constants and types for the SSH channel table block.
`timescale 1ns / 1ps
package sctfc_pkg;
    localparam int CONNECTIONS       = 4;
    localparam int CHANNELS_PER_CONN = 8;
    localparam int CONN_W  = 2;
    localparam int SLOT_W  = (CHANNELS_PER_CONN > 1) ? $clog2(CHANNELS_PER_CONN) : 1;
    localparam int ENTRIES = CONNECTIONS * CHANNELS_PER_CONN;
    localparam int ADDR_W  = $clog2(ENTRIES);

    typedef enum logic [2:0] {
        M_OPEN = 3'd0, M_REQUEST = 3'd1, M_DATA_IN = 3'd2, M_DATA_OUT = 3'd3,
        M_ADJUST = 3'd4, M_PEER_CLOSE = 3'd5, M_LOCAL_CLOSE = 3'd6, M_CONN_RESET = 3'd7
    } t_mode;

    localparam logic [1:0] ST_OK = 2'd0, ST_NO_CHAN = 2'd1, ST_OVERRUN = 2'd2,
                           ST_SEND_EXCEEDS = 2'd3;
    localparam logic [7:0] MSG_NONE = 8'd0, MSG_OPEN_CONF = 8'd91, MSG_OPEN_FAIL = 8'd92,
                           MSG_WIN_ADJ = 8'd93, MSG_DATA = 8'd94, MSG_EOF = 8'd96,
                           MSG_CLOSE = 8'd97, MSG_SUCCESS = 8'd99, MSG_FAILURE = 8'd100;
    localparam logic [31:0] RSN_PROHIBITED = 32'd1, RSN_CONNECT = 32'd2,
                            RSN_UNKNOWN = 32'd3, RSN_FULL = 32'd4;
    localparam logic [1:0] REG_LWIN = 2'd0, REG_MAXPKT = 2'd1, REG_FWD = 2'd2,
                           REG_SINK = 2'd3;
    localparam logic [1:0] DL_NONE = 2'd0, DL_APP = 2'd1, DL_FWD = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_READ, S_EXEC, S_OUT1, S_OUT2
    } t_state;

    // one stored channel record
    typedef struct packed {
        logic        is_forward;
        logic [31:0] peer_channel;
        logic [31:0] rx_window;
        logic [31:0] tx_window;
        logic [31:0] peer_max_packet;
    } t_slot;

    // one result item
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  msg_code;
        logic [31:0] recipient_id;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [1:0]  deliver_to;
        logic [2:0]  channel_index;
        logic        last;
    } t_result;
endpackage

>>> rtl/sctfc_slot_ram.sv
// Module: channel record memory, one write and one registered read port.
`timescale 1ns / 1ps
module sctfc_slot_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [sctfc_pkg::ADDR_W-1:0] i_waddr,
    input  sctfc_pkg::t_slot          i_wdata,
    input  logic [sctfc_pkg::ADDR_W-1:0] i_raddr,
    output sctfc_pkg::t_slot          o_rdata
);
    import sctfc_pkg::*;

    t_slot r_mem [ENTRIES];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/ssh_channel_table_flow_control.sv
// Top level: SSH connection channel table with window flow control.
// One message event is taken at a time. An open scans the connection's open
// marks one slot a cycle until it finds a free one or has passed them all;
// events on an open channel read the slot record from the channel memory in
// READ and use it in EXEC; an accepted open, successful data events and adjust
// events write the record back. A close gives two results, EOF then CLOSE.
// A connection reset clears all of that connection's open marks together. Open
// marks live in flip-flops; the per-slot records live in a single memory.
`timescale 1ns / 1ps
module ssh_channel_table_flow_control (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_mode,
    input  logic [1:0]  i_conn,
    input  logic [31:0] i_channel_id,
    input  logic [1:0]  i_chan_type,
    input  logic [31:0] i_sender_id,
    input  logic [31:0] i_window_value,
    input  logic [31:0] i_peer_packet_limit,
    input  logic [31:0] i_data_len,
    input  logic        i_want_reply,
    input  logic        i_request_known,
    input  logic        i_connect_ok,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_msg_code,
    output logic [31:0] o_recipient_id,
    output logic [31:0] o_word_a,
    output logic [31:0] o_word_b,
    output logic [31:0] o_word_c,
    output logic [1:0]  o_deliver_to,
    output logic [2:0]  o_channel_index,
    output logic        o_last
);
    import sctfc_pkg::*;

    // configuration registers
    logic [31:0] r_lwin, r_maxpkt;
    logic        r_fwd_en, r_sink_en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lwin    <= 32'd65536;
            r_maxpkt  <= 32'd32768;
            r_fwd_en  <= 1'b0;
            r_sink_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LWIN:   r_lwin    <= i_cfg_data;
                REG_MAXPKT: r_maxpkt  <= i_cfg_data;
                REG_FWD:    r_fwd_en  <= i_cfg_data[0];
                REG_SINK:   r_sink_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // captured input transaction
    t_mode       r_mode;
    logic [CONN_W-1:0] r_conn;
    logic [31:0] r_id, r_sender, r_wval, r_plim, r_dlen;
    logic [1:0]  r_ctype;
    logic        r_want, r_known, r_cok;
    logic        accept;
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= t_mode'(i_mode);
            r_conn   <= i_conn;
            r_id     <= i_channel_id;
            r_ctype  <= i_chan_type;
            r_sender <= i_sender_id;
            r_wval   <= i_window_value;
            r_plim   <= i_peer_packet_limit;
            r_dlen   <= i_data_len;
            r_want   <= i_want_reply;
            r_known  <= i_request_known;
            r_cok    <= i_connect_ok;
        end
    end

    t_state r_state, n_state;
    logic [SLOT_W:0] r_scan;
    logic [SLOT_W-1:0] r_slot;
    logic r_open [ENTRIES];
    t_result r_res1, r_res2, n_res1, n_res2;

    wire [SLOT_W-1:0] scan_idx = r_scan[SLOT_W-1:0];
    wire [ADDR_W-1:0] scan_addr = ADDR_W'(r_conn) * ADDR_W'(CHANNELS_PER_CONN)
                                  + ADDR_W'(scan_idx);
    wire [ADDR_W-1:0] slot_addr = ADDR_W'(r_conn) * ADDR_W'(CHANNELS_PER_CONN)
                                  + ADDR_W'(r_slot);
    wire id_ok = (r_id < 32'(CHANNELS_PER_CONN));
    wire conn_ok = (32'(r_conn) < 32'(CONNECTIONS));
    wire [ADDR_W-1:0] id_addr = ADDR_W'(r_conn) * ADDR_W'(CHANNELS_PER_CONN)
                                + ADDR_W'(r_id[SLOT_W-1:0]);

    // memory: record is read during READ so that it is ready in EXEC
    logic  mem_we;
    t_slot mem_wdata, mem_rdata;
    sctfc_slot_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(slot_addr),
        .i_wdata(mem_wdata),
        .i_raddr(id_addr),
        .o_rdata(mem_rdata)
    );

    assign accept  = (r_state == S_IDLE) && i_valid;
    assign o_stall = (r_state != S_IDLE);

    // execute step: compute results and write-back
    logic        open_clr, open_set, id_open;
    logic [31:0] lw_new, dl_sum;
    logic [32:0] pw_sum;
    logic [1:0]  dsink;
    always_comb begin
        n_res1    = '0;
        n_res2    = '0;
        n_res1.last = 1'b1;
        n_res2.last = 1'b1;
        mem_we    = 1'b0;
        mem_wdata = mem_rdata;
        open_set  = 1'b0;
        open_clr  = 1'b0;
        lw_new    = mem_rdata.rx_window - r_dlen;
        pw_sum    = {1'b0, mem_rdata.tx_window} + {1'b0, r_wval};
        dl_sum    = 32'd0;
        id_open   = id_ok && r_open[id_addr];
        dsink     = DL_NONE;
        if (r_dlen != 32'd0) begin
            if (mem_rdata.is_forward) dsink = r_fwd_en ? DL_FWD : DL_NONE;
            else                      dsink = r_sink_en ? DL_APP : DL_NONE;
        end
        if (r_state == S_EXEC) begin
            case (r_mode)
                M_OPEN: begin
                    n_res1.msg_code = MSG_OPEN_FAIL;
                    n_res1.recipient_id = r_sender;
                    if (r_ctype > 2'd1) n_res1.word_a = RSN_UNKNOWN;
                    else if (r_ctype == 2'd1 && !r_fwd_en) n_res1.word_a = RSN_PROHIBITED;
                    else if (r_scan[SLOT_W] || 32'(r_scan) >= 32'(CHANNELS_PER_CONN))
                        n_res1.word_a = RSN_FULL;
                    else if (r_ctype == 2'd1 && !r_cok) n_res1.word_a = RSN_CONNECT;
                    else begin
                        open_set = 1'b1;
                        mem_we = 1'b1;
                        mem_wdata.is_forward = (r_ctype == 2'd1);
                        mem_wdata.peer_channel = r_sender;
                        mem_wdata.rx_window = r_lwin;
                        mem_wdata.tx_window = r_wval;
                        mem_wdata.peer_max_packet = r_plim;
                        n_res1.msg_code = MSG_OPEN_CONF;
                        n_res1.word_a = 32'(r_slot);
                        n_res1.word_b = r_lwin;
                        n_res1.word_c = r_maxpkt;
                        n_res1.channel_index = 3'(r_slot);
                    end
                end
                M_REQUEST: begin
                    if (r_want) begin
                        n_res1.msg_code = r_known ? MSG_SUCCESS : MSG_FAILURE;
                        n_res1.recipient_id = mem_rdata.peer_channel;
                    end
                end
                M_DATA_IN: begin
                    if (r_dlen > mem_rdata.rx_window) n_res1.status = ST_OVERRUN;
                    else begin
                        mem_we = 1'b1;
                        n_res1.deliver_to = dsink;
                        n_res1.channel_index = 3'(r_slot);
                        if (lw_new < {1'b0, r_lwin[31:1]}) begin
                            dl_sum = r_lwin - lw_new;
                            mem_wdata.rx_window = r_lwin;
                            n_res1.msg_code = MSG_WIN_ADJ;
                            n_res1.recipient_id = mem_rdata.peer_channel;
                            n_res1.word_a = dl_sum;
                        end else mem_wdata.rx_window = lw_new;
                    end
                end
                M_DATA_OUT: begin
                    if (r_dlen > mem_rdata.tx_window || r_dlen > mem_rdata.peer_max_packet)
                        n_res1.status = ST_SEND_EXCEEDS;
                    else begin
                        mem_we = 1'b1;
                        mem_wdata.tx_window = mem_rdata.tx_window - r_dlen;
                        n_res1.msg_code = MSG_DATA;
                        n_res1.recipient_id = mem_rdata.peer_channel;
                        n_res1.word_a = r_dlen;
                        n_res1.channel_index = 3'(r_slot);
                    end
                end
                M_ADJUST: begin
                    mem_we = 1'b1;
                    mem_wdata.tx_window = pw_sum[32] ? 32'hFFFF_FFFF : pw_sum[31:0];
                end
                default: begin
                    open_clr = 1'b1;
                    n_res1.msg_code = MSG_EOF;
                    n_res1.recipient_id = mem_rdata.peer_channel;
                    n_res1.last = 1'b0;
                    n_res2.msg_code = MSG_CLOSE;
                    n_res2.recipient_id = mem_rdata.peer_channel;
                end
            endcase
        end else if (r_state == S_READ) begin
            // plain result for events that never reach EXEC
            if (!conn_ok || (r_mode != M_CONN_RESET && r_mode != M_OPEN && !id_open))
                n_res1.status = ST_NO_CHAN;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_READ;
            S_READ: begin
                if (!conn_ok) n_state = S_OUT1;
                else if (r_mode == M_CONN_RESET) n_state = S_OUT1;
                else if (r_mode == M_OPEN) n_state = S_SCAN;
                else if (!id_open) n_state = S_OUT1;
                else n_state = S_EXEC;
            end
            S_SCAN: begin
                if (r_scan[SLOT_W] || 32'(r_scan) >= 32'(CHANNELS_PER_CONN)
                    || !r_open[scan_addr]) n_state = S_EXEC;
            end
            S_EXEC: n_state = S_OUT1;
            S_OUT1: if (!i_stall) n_state = (r_res1.last) ? S_IDLE : S_OUT2;
            S_OUT2: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers and open marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scan  <= '0;
            r_slot  <= '0;
            for (int k = 0; k < ENTRIES; k++) r_open[k] <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_READ: begin
                    r_scan <= '0;
                    r_slot <= r_id[SLOT_W-1:0];
                    if (conn_ok && r_mode == M_CONN_RESET) begin
                        for (int k = 0; k < CHANNELS_PER_CONN; k++)
                            r_open[ADDR_W'(r_conn) * ADDR_W'(CHANNELS_PER_CONN)
                                   + ADDR_W'(k)] <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_slot <= scan_idx;
                    if (!(r_scan[SLOT_W] || 32'(r_scan) >= 32'(CHANNELS_PER_CONN)
                          || !r_open[scan_addr])) r_scan <= r_scan + 1'b1;
                end
                S_EXEC: begin
                    if (open_set) r_open[slot_addr] <= 1'b1;
                    if (open_clr) r_open[slot_addr] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // result registers: plain results in READ, computed ones in EXEC
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ || r_state == S_EXEC) begin
            r_res1 <= n_res1;
            r_res2 <= n_res2;
        end else if (r_state == S_OUT1 && !i_stall) begin
            r_res1 <= r_res2;
        end
    end

    assign o_valid         = (r_state == S_OUT1) || (r_state == S_OUT2);
    assign o_status        = r_res1.status;
    assign o_msg_code      = r_res1.msg_code;
    assign o_recipient_id  = r_res1.recipient_id;
    assign o_word_a        = r_res1.word_a;
    assign o_word_b        = r_res1.word_b;
    assign o_word_c        = r_res1.word_c;
    assign o_deliver_to    = r_res1.deliver_to;
    assign o_channel_index = r_res1.channel_index;
    assign o_last          = r_res1.last;
endmodule

>>> tb/sv/tb_ssh_channel_table_flow_control.sv
// Testbench: channel table open/data/window/close sequences checked against a local predictor.
`timescale 1ns / 1ps
module tb_ssh_channel_table_flow_control;
    import sctfc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_mode;
    logic [1:0]  i_conn;
    logic [31:0] i_channel_id;
    logic [1:0]  i_chan_type;
    logic [31:0] i_sender_id;
    logic [31:0] i_window_value;
    logic [31:0] i_peer_packet_limit;
    logic [31:0] i_data_len;
    logic        i_want_reply;
    logic        i_request_known;
    logic        i_connect_ok;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [7:0]  o_msg_code;
    logic [31:0] o_recipient_id;
    logic [31:0] o_word_a;
    logic [31:0] o_word_b;
    logic [31:0] o_word_c;
    logic [1:0]  o_deliver_to;
    logic [2:0]  o_channel_index;
    logic        o_last;

    ssh_channel_table_flow_control dut (.*);

    // one channel event as offered to the block
    typedef struct {
        t_mode       mode;
        logic [1:0]  conn;
        logic [31:0] chan;
        logic [1:0]  ctype;
        logic [31:0] sender;
        logic [31:0] wval;
        logic [31:0] plim;
        logic [31:0] dlen;
        logic        want;
        logic        known;
        logic        cok;
    } t_event;

    // predictor copy of the table and registers
    logic [31:0] lwin_size;
    logic [31:0] maxpkt_size;
    logic        fwd_en;
    logic        sink_en;
    logic        tbl_open   [CONNECTIONS][CHANNELS_PER_CONN];
    logic        tbl_fwd    [CONNECTIONS][CHANNELS_PER_CONN];
    logic [31:0] tbl_peer   [CONNECTIONS][CHANNELS_PER_CONN];
    logic [31:0] tbl_lwin   [CONNECTIONS][CHANNELS_PER_CONN];
    logic [31:0] tbl_pwin   [CONNECTIONS][CHANNELS_PER_CONN];
    logic [31:0] tbl_pmax   [CONNECTIONS][CHANNELS_PER_CONN];

    t_result expected_msgs[$];
    int      error_count;
    int      result_count;
    bit      hold_off;
    bit      stall_random;

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
                 result_count);
        error_count++;
    endtask

    function automatic t_result mk_result(logic [1:0] st, logic [7:0] code, logic [31:0] rcpt,
                                          logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                          logic [1:0] dl, logic [2:0] idx, logic lst);
        t_result r;
        r.status = st; r.msg_code = code; r.recipient_id = rcpt;
        r.word_a = a; r.word_b = b; r.word_c = c;
        r.deliver_to = dl; r.channel_index = idx; r.last = lst;
        return r;
    endfunction

    function automatic void reset_table();
        lwin_size = 32'd65536; maxpkt_size = 32'd32768; fwd_en = 1'b0; sink_en = 1'b1;
        for (int c = 0; c < CONNECTIONS; c++)
            for (int s = 0; s < CHANNELS_PER_CONN; s++) begin
                tbl_open[c][s] = 1'b0; tbl_fwd[c][s] = 1'b0;
            end
    endfunction

    // work out the results of one event and update the table
    function automatic void predict_event(t_event e);
        int          slot;
        int          id;
        logic [31:0] lw;
        logic [31:0] sum;
        logic [1:0]  dl;
        logic [31:0] p;
        slot = -1;
        id = e.chan;
        if (e.mode == M_CONN_RESET) begin
            for (int s = 0; s < CHANNELS_PER_CONN; s++) tbl_open[e.conn][s] = 1'b0;
            expected_msgs.push_back(mk_result(ST_OK, MSG_NONE, 0, 0, 0, 0, DL_NONE, 0, 1));
            return;
        end
        if (e.mode == M_OPEN) begin
            if (e.ctype > 2'd1) begin
                expected_msgs.push_back(mk_result(ST_OK, MSG_OPEN_FAIL, e.sender, RSN_UNKNOWN,
                                                  0, 0, DL_NONE, 0, 1));
                return;
            end
            if (e.ctype == 2'd1 && !fwd_en) begin
                expected_msgs.push_back(mk_result(ST_OK, MSG_OPEN_FAIL, e.sender,
                                                  RSN_PROHIBITED, 0, 0, DL_NONE, 0, 1));
                return;
            end
            for (int s = CHANNELS_PER_CONN - 1; s >= 0; s--)
                if (!tbl_open[e.conn][s]) slot = s;
            if (slot < 0) begin
                expected_msgs.push_back(mk_result(ST_OK, MSG_OPEN_FAIL, e.sender, RSN_FULL,
                                                  0, 0, DL_NONE, 0, 1));
                return;
            end
            if (e.ctype == 2'd1 && !e.cok) begin
                expected_msgs.push_back(mk_result(ST_OK, MSG_OPEN_FAIL, e.sender, RSN_CONNECT,
                                                  0, 0, DL_NONE, 0, 1));
                return;
            end
            tbl_open[e.conn][slot] = 1'b1;
            tbl_fwd[e.conn][slot]  = (e.ctype == 2'd1);
            tbl_peer[e.conn][slot] = e.sender;
            tbl_lwin[e.conn][slot] = lwin_size;
            tbl_pwin[e.conn][slot] = e.wval;
            tbl_pmax[e.conn][slot] = e.plim;
            expected_msgs.push_back(mk_result(ST_OK, MSG_OPEN_CONF, e.sender, 32'(slot),
                                              lwin_size, maxpkt_size, DL_NONE, 3'(slot), 1));
            return;
        end
        if (e.chan >= CHANNELS_PER_CONN || !tbl_open[e.conn][id]) begin
            expected_msgs.push_back(mk_result(ST_NO_CHAN, MSG_NONE, 0, 0, 0, 0, DL_NONE, 0, 1));
            return;
        end
        p = tbl_peer[e.conn][id];
        case (e.mode)
            M_REQUEST: begin
                if (!e.want)
                    expected_msgs.push_back(mk_result(ST_OK, MSG_NONE, 0, 0, 0, 0, DL_NONE,
                                                      0, 1));
                else
                    expected_msgs.push_back(mk_result(ST_OK, e.known ? MSG_SUCCESS :
                                                      MSG_FAILURE, p, 0, 0, 0, DL_NONE, 0, 1));
            end
            M_DATA_IN: begin
                lw = tbl_lwin[e.conn][id];
                if (e.dlen > lw) begin
                    expected_msgs.push_back(mk_result(ST_OVERRUN, MSG_NONE, 0, 0, 0, 0,
                                                      DL_NONE, 0, 1));
                    return;
                end
                lw = lw - e.dlen;
                dl = DL_NONE;
                if (e.dlen != 0)
                    dl = tbl_fwd[e.conn][id] ? (fwd_en ? DL_FWD : DL_NONE)
                                             : (sink_en ? DL_APP : DL_NONE);
                if (lw < (lwin_size >> 1)) begin
                    tbl_lwin[e.conn][id] = lwin_size;
                    expected_msgs.push_back(mk_result(ST_OK, MSG_WIN_ADJ, p, lwin_size - lw,
                                                      0, 0, dl, 3'(id), 1));
                end else begin
                    tbl_lwin[e.conn][id] = lw;
                    expected_msgs.push_back(mk_result(ST_OK, MSG_NONE, 0, 0, 0, 0, dl,
                                                      3'(id), 1));
                end
            end
            M_DATA_OUT: begin
                if (e.dlen > tbl_pwin[e.conn][id] || e.dlen > tbl_pmax[e.conn][id])
                    expected_msgs.push_back(mk_result(ST_SEND_EXCEEDS, MSG_NONE, 0, 0, 0, 0,
                                                      DL_NONE, 0, 1));
                else begin
                    tbl_pwin[e.conn][id] = tbl_pwin[e.conn][id] - e.dlen;
                    expected_msgs.push_back(mk_result(ST_OK, MSG_DATA, p, e.dlen, 0, 0,
                                                      DL_NONE, 3'(id), 1));
                end
            end
            M_ADJUST: begin
                sum = tbl_pwin[e.conn][id] + e.wval;
                tbl_pwin[e.conn][id] = (sum < tbl_pwin[e.conn][id]) ? 32'hFFFF_FFFF : sum;
                expected_msgs.push_back(mk_result(ST_OK, MSG_NONE, 0, 0, 0, 0, DL_NONE, 0, 1));
            end
            default: begin
                tbl_open[e.conn][id] = 1'b0;
                expected_msgs.push_back(mk_result(ST_OK, MSG_EOF, p, 0, 0, 0, DL_NONE, 0, 0));
                expected_msgs.push_back(mk_result(ST_OK, MSG_CLOSE, p, 0, 0, 0, DL_NONE, 0, 1));
            end
        endcase
    endfunction

    // random gap, mostly short, sometimes long
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one event and wait until it is accepted
    task automatic send_event(t_event e);
        int gap;
        gap = rand_gap();
        repeat (gap) @(negedge i_clk);
        i_mode = e.mode; i_conn = e.conn; i_channel_id = e.chan; i_chan_type = e.ctype;
        i_sender_id = e.sender; i_window_value = e.wval; i_peer_packet_limit = e.plim;
        i_data_len = e.dlen; i_want_reply = e.want; i_request_known = e.known;
        i_connect_ok = e.cok;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_event(e);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_msgs.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_LWIN:   lwin_size = val;
            REG_MAXPKT: maxpkt_size = val;
            REG_FWD:    fwd_en = val[0];
            default:    sink_en = val[0];
        endcase
    endtask

    function automatic t_event blank_event(t_mode m, logic [1:0] c, logic [31:0] ch);
        t_event e;
        e.mode = m; e.conn = c; e.chan = ch; e.ctype = 2'd0;
        e.sender = $urandom; e.wval = $urandom; e.plim = $urandom; e.dlen = $urandom;
        e.want = 1'($urandom_range(0, 1)); e.known = 1'($urandom_range(0, 1));
        e.cok = 1'($urandom_range(0, 1));
        return e;
    endfunction

    // mostly valid channel ids with small lengths; some noise everywhere
    function automatic t_event random_event();
        t_event e;
        int     r;
        e = blank_event(t_mode'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                        $urandom_range(0, CHANNELS_PER_CONN - 1));
        r = $urandom_range(0, 99);
        if (r < 5) e.chan = $urandom;
        if (e.mode == M_CONN_RESET && $urandom_range(0, 3) != 0)
            e.mode = M_OPEN;
        if (e.mode == M_OPEN) e.ctype = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                                    : 2'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0) begin
            e.dlen = $urandom_range(0, 3) == 0 ? $urandom_range(0, 70000)
                                               : $urandom_range(0, 9000);
            e.wval = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 100000);
            e.plim = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40000);
        end
        return e;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (expected_msgs.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_msg_code), 32'd0);
            end else begin
                want = expected_msgs.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_msg_code !== want.msg_code)
                    report_mismatch("msg_code", o_msg_code, want.msg_code);
                if (o_recipient_id !== want.recipient_id)
                    report_mismatch("recipient_id", o_recipient_id, want.recipient_id);
                if (o_word_a !== want.word_a) report_mismatch("word_a", o_word_a, want.word_a);
                if (o_word_b !== want.word_b) report_mismatch("word_b", o_word_b, want.word_b);
                if (o_word_c !== want.word_c) report_mismatch("word_c", o_word_c, want.word_c);
                if (o_deliver_to !== want.deliver_to)
                    report_mismatch("deliver_to", o_deliver_to, want.deliver_to);
                if (o_channel_index !== want.channel_index)
                    report_mismatch("channel_index", o_channel_index, want.channel_index);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
            end
        end
    end

    // receiver stall: random gaps, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_off) i_stall <= 1'b1;
        else if (!stall_random) i_stall <= 1'b0;
        else i_stall <= (rand_gap() != 0);
    end

    task automatic test_directed_open_and_fail();
        t_event e;
        // unknown types, prohibited forward, then forward allowed with connect failure
        e = blank_event(M_OPEN, 0, 0); e.ctype = 2'd2; send_event(e);
        e = blank_event(M_OPEN, 0, 0); e.ctype = 2'd3; send_event(e);
        e = blank_event(M_OPEN, 0, 0); e.ctype = 2'd1; send_event(e);
        wait_drained();
        write_reg(REG_FWD, 32'd1);
        e = blank_event(M_OPEN, 1, 0); e.ctype = 2'd1; e.cok = 1'b0; send_event(e);
        // fill connection 0 then overflow it
        for (int i = 0; i < CHANNELS_PER_CONN + 1; i++) begin
            e = blank_event(M_OPEN, 0, 0); e.ctype = 2'($urandom_range(0, 1)); e.cok = 1'b1;
            e.wval = (i == 0) ? 32'hFFFF_FFF0 : 32'd1000; e.plim = 32'hFFFF_FFFF;
            send_event(e);
        end
    endtask

    task automatic test_directed_channel_ops();
        t_event e;
        e = blank_event(M_REQUEST, 0, 1); e.want = 0; send_event(e);
        e = blank_event(M_REQUEST, 0, 1); e.want = 1; e.known = 1; send_event(e);
        e = blank_event(M_REQUEST, 0, 2); e.want = 1; e.known = 0; send_event(e);
        e = blank_event(M_DATA_IN, 0, 0); e.dlen = 0; send_event(e);
        e = blank_event(M_DATA_IN, 0, 0); e.dlen = 32'hFFFF_FFFF; send_event(e);
        e = blank_event(M_DATA_IN, 0, 0); e.dlen = 40000; send_event(e);
        e = blank_event(M_DATA_OUT, 0, 1); e.dlen = 2000; send_event(e);
        e = blank_event(M_DATA_OUT, 0, 1); e.dlen = 500; send_event(e);
        e = blank_event(M_ADJUST, 0, 0); e.wval = 32'hFFFF_FFFF; send_event(e);
        e = blank_event(M_PEER_CLOSE, 0, 3); send_event(e);
        e = blank_event(M_LOCAL_CLOSE, 0, 3); send_event(e);
        e = blank_event(M_DATA_IN, 2, 32'hFFFF_FFFF); send_event(e);
        e = blank_event(M_CONN_RESET, 0, 0); send_event(e);
        wait_drained();
    endtask

    task automatic test_random_phase(input int count);
        for (int i = 0; i < count; i++) send_event(random_event());
        wait_drained();
    endtask

    // receiver holds off while events keep coming
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 20; i++) send_event(random_event());
        join
        wait_drained();
    endtask

    task automatic test_config_sweep();
        write_reg(REG_LWIN, 32'd1); write_reg(REG_MAXPKT, 32'd1);
        write_reg(REG_FWD, 32'd0); write_reg(REG_SINK, 32'd0);
        test_random_phase(250);
        write_reg(REG_LWIN, 32'hFFFF_FFFF); write_reg(REG_MAXPKT, 32'hFFFF_FFFF);
        write_reg(REG_FWD, 32'd1); write_reg(REG_SINK, 32'd1);
        test_random_phase(250);
        write_reg(REG_LWIN, 32'd9000); write_reg(REG_MAXPKT, $urandom);
        write_reg(REG_SINK, 32'd0);
        test_random_phase(250);
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = REG_LWIN; i_cfg_data = 0;
        i_valid = 1'b0; i_mode = M_OPEN; i_conn = 0; i_channel_id = 0; i_chan_type = 0;
        i_sender_id = 0; i_window_value = 0; i_peer_packet_limit = 0; i_data_len = 0;
        i_want_reply = 0; i_request_known = 0; i_connect_ok = 0; i_stall = 1'b0;
        error_count = 0; result_count = 0; hold_off = 1'b0; stall_random = 1'b0;
        reset_table();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (4) @(negedge i_clk);
        test_directed_open_and_fail();
        test_directed_channel_ops();
        stall_random = 1'b1;
        test_random_phase(300);
        test_backpressure();
        test_config_sweep();
        if (error_count == 0)
            $display("tb_ssh_channel_table_flow_control: done, clean");
        else
            $display("tb_ssh_channel_table_flow_control: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("tb_ssh_channel_table_flow_control: done, errors");
        $finish;
    end
endmodule
